### rtl/core/xfr_pkg.sv
// xfr_pkg: shared widths, frame constants and codes of the frame receiver
package xfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned StateW = 3;

  localparam logic [ByteW-1:0] FrameStx    = 8'h02;
  localparam logic [ByteW-1:0] FrameEtx    = 8'h03;
  localparam logic [ByteW-1:0] MaxLenReset = 8'd200;

  // item operation codes, code 3 is unused
  typedef enum logic [ModeW-1:0] {
    ModeRx      = 2'd0,
    ModeRead    = 2'd1,
    ModeRelease = 2'd2
  } mode_e;

  // receiver states as reported on the result channel
  typedef enum logic [StateW-1:0] {
    StWaitStx = 3'd0,
    StLength  = 3'd1,
    StData    = 3'd2,
    StCheck   = 3'd3,
    StEtx     = 3'd4,
    StReady   = 3'd5,
    StError   = 3'd6
  } rx_state_e;

endpackage

### rtl/core/xfr_if.sv
// xfr_if: handshake channels of the frame receiver (config, input items, results)

interface xfr_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [xfr_pkg::ByteW-1:0] max_len;

  modport source (output valid, output max_len, input ready);
  modport sink (input valid, input max_len, output ready);
endinterface

interface xfr_in_if;
  logic                      valid;
  logic                      ready;
  logic [xfr_pkg::ModeW-1:0] mode;
  logic [xfr_pkg::ByteW-1:0] rx_byte;
  logic [xfr_pkg::ByteW-1:0] read_index;

  modport source (output valid, output mode, output rx_byte, output read_index,
                  input ready);
  modport sink (input valid, input mode, input rx_byte, input read_index,
                output ready);
endinterface

interface xfr_out_if;
  logic                       valid;
  logic                       ready;
  logic [xfr_pkg::StateW-1:0] rx_state;
  logic                       frame_ready;
  logic [xfr_pkg::ByteW-1:0]  payload_length;
  logic [xfr_pkg::ByteW-1:0]  read_data;
  logic [xfr_pkg::ByteW-1:0]  released_length;

  modport source (output valid, output rx_state, output frame_ready,
                  output payload_length, output read_data, output released_length,
                  input ready);
  modport sink (input valid, input rx_state, input frame_ready,
                input payload_length, input read_data, input released_length,
                output ready);
endinterface

### rtl/core/xfr_ram.sv
// xfr_ram: generic single-write, single-read RAM with registered read data
module xfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/xor_frame_receiver.sv
// xor_frame_receiver: STX/LEN/payload/XOR/ETX frame receiver with payload buffer
//
//   channel | direction | handshake     | payload
//   --------+-----------+---------------+--------------------------------------------
//   cfg_i   | in        | valid/ready   | max_len
//   in_i    | in        | valid/ready   | mode, rx_byte, read_index
//   out_o   | out       | valid/ready   | rx_state, frame_ready, payload_length,
//           |           |               | read_data, released_length
//
// One item per clock sustained while results are taken; each result passes the
// status snapshot (taken beside the registered buffer read) and the result register.
// The receiver state is updated at the accept edge, so items may follow back to
// back. Two result slots decouple the sides: input stalls only when both are full
// and the result is not taken. Reset clears control state and sets max_len to 200;
// the payload buffer is not cleared, reads are gated by the frame length.
module xor_frame_receiver #(
  parameter int unsigned BUFFER_DEPTH = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  xfr_cfg_if.sink  cfg_i,
  xfr_in_if.sink   in_i,
  xfr_out_if.source out_o
);
  import xfr_pkg::*;

  localparam int unsigned AddrW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [ByteW:0] DepthLim = (ByteW + 1)'(BUFFER_DEPTH);

  // receiver state
  logic [ByteW-1:0] max_len_q;
  rx_state_e        state_q, state_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] idx_q, idx_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic             rdy_q, rdy_d;

  // result pipeline
  logic             a_valid_q, b_valid_q;
  rx_state_e        a_state_q;
  logic             a_rdy_q;
  logic [ByteW-1:0] a_len_q, a_rel_q;
  logic             a_gate_q;
  logic [StateW-1:0] b_state_q;
  logic             b_rdy_q;
  logic [ByteW-1:0] b_len_q, b_rel_q, b_rd_q;

  logic             in_acc, a_adv, out_acc;
  mode_e            mode;
  logic [ByteW-1:0] rx_b;
  logic             rd_gate;
  logic [ByteW-1:0] rel;
  logic             ram_we;
  logic [ByteW-1:0] ram_rdata;

  assign out_acc  = b_valid_q && out_o.ready;
  assign a_adv    = a_valid_q && (!b_valid_q || out_o.ready);
  assign in_i.ready = !a_valid_q || a_adv;
  assign in_acc   = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign mode = mode_e'(in_i.mode);
  assign rx_b = in_i.rx_byte;

  // next state for one item
  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    idx_d   = idx_q;
    xor_d   = xor_q;
    rdy_d   = rdy_q;
    rd_gate = 1'b0;
    rel     = '0;
    ram_we  = 1'b0;
    case (mode)
      ModeRx: begin
        case (state_q)
          StWaitStx, StError: begin
            if (rx_b == FrameStx) begin
              state_d = StLength;
            end
          end
          StLength: begin
            len_d = rx_b;
            idx_d = '0;
            if (rx_b > max_len_q) begin
              state_d = StError;
            end else begin
              xor_d   = FrameStx ^ rx_b;
              state_d = (rx_b == '0) ? StCheck : StData;
            end
          end
          StData: begin
            if (idx_q < len_q) begin
              ram_we = ({1'b0, idx_q} < DepthLim);
              xor_d  = xor_q ^ rx_b;
              idx_d  = idx_q + 1'b1;
              if (idx_d >= len_q) begin
                state_d = StCheck;
              end
            end else begin
              state_d = StError;
            end
          end
          StCheck: begin
            state_d = (rx_b == xor_q) ? StEtx : StError;
          end
          StEtx: begin
            if (rx_b == FrameEtx) begin
              state_d = StReady;
              rdy_d   = 1'b1;
            end else begin
              state_d = StError;
            end
          end
          default: begin
          end
        endcase
      end
      ModeRead: begin
        rd_gate = rdy_q && (in_i.read_index < len_q) &&
                  ({1'b0, in_i.read_index} < DepthLim);
      end
      ModeRelease: begin
        if (rdy_q) begin
          rel     = len_q;
          state_d = StWaitStx;
          len_d   = '0;
          idx_d   = '0;
          xor_d   = '0;
          rdy_d   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // config register and receiver state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
      state_q   <= StWaitStx;
      len_q     <= '0;
      idx_q     <= '0;
      xor_q     <= '0;
      rdy_q     <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        max_len_q <= cfg_i.max_len;
      end
      if (in_acc) begin
        state_q <= state_d;
        len_q   <= len_d;
        idx_q   <= idx_d;
        xor_q   <= xor_d;
        rdy_q   <= rdy_d;
      end
    end
  end

  // payload buffer
  xfr_ram #(
    .Width(ByteW),
    .Depth(BUFFER_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (in_acc && ram_we),
    .waddr_i(idx_q[AddrW-1:0]),
    .wdata_i(rx_b),
    .re_i   (in_acc && rd_gate),
    .raddr_i(in_i.read_index[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  // pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        a_valid_q <= 1'b1;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
      if (a_adv) begin
        b_valid_q <= 1'b1;
      end else if (out_acc) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  // status snapshot while the buffer read is in flight
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_state_q <= state_d;
      a_rdy_q   <= rdy_d;
      a_len_q   <= len_d;
      a_rel_q   <= rel;
      a_gate_q  <= rd_gate;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_state_q <= a_state_q;
      b_rdy_q   <= a_rdy_q;
      b_len_q   <= a_len_q;
      b_rel_q   <= a_rel_q;
      b_rd_q    <= a_gate_q ? ram_rdata : '0;
    end
  end

  assign out_o.valid           = b_valid_q;
  assign out_o.rx_state        = b_state_q;
  assign out_o.frame_ready     = b_rdy_q;
  assign out_o.payload_length  = b_len_q;
  assign out_o.read_data       = b_rd_q;
  assign out_o.released_length = b_rel_q;

endmodule
